### sv/assert_macros.svh
// Assertion macros shared by the RTL of the serial EEPROM slave.
// No dependencies; included by files that carry concurrent checks.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define ASSERT_IMP(lbl, clk, rst_n, a, c, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define ASSERT_NXT(lbl, clk, rst_n, a, c, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) else $error(msg);

// Invariant that must hold at every edge outside reset.
`define ASSERT_ALWAYS(lbl, clk, rst_n, c, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (c)) else $error(msg);

`endif

### sv/ise_pkg.sv
`timescale 1ns / 1ps
// Shared types, constants and helpers for the serial EEPROM slave.
// No dependencies.
package ise_pkg;

	localparam int ADDR_BITS  = 13;
	localparam int DEPTH      = 1 << ADDR_BITS;
	localparam int LOG2_W     = $clog2(ADDR_BITS + 1);
	localparam int WADDR_W    = 16;
	localparam int SIZE_W     = 5;
	localparam int SMALL_LOG2 = 8;   // parts below 256 bytes
	localparam int MID_LOG2   = 12;  // parts below 4096 bytes
	localparam logic [SIZE_W-1:0] SIZE_RESET = SIZE_W'(7);
	localparam logic [3:0] BITS_PER_BYTE = 4'd8;
	localparam logic [7:0] ERASED = 8'hFF;

	typedef enum logic [3:0] {
		PH_IDLE,
		PH_START,
		PH_DEV_ACK,
		PH_ADDR_HI,
		PH_ADDR_HI_ACK,
		PH_ADDR_LO,
		PH_ADDR_LO_ACK,
		PH_READ,
		PH_READ_ACK,
		PH_WRITE,
		PH_WRITE_ACK
	} ise_phase_t;

	typedef struct packed {
		logic                 we;
		logic [ADDR_BITS-1:0] waddr;
		logic [7:0]           wdata;
		logic                 re;
		logic [ADDR_BITS-1:0] raddr;
	} ise_ram_req_t;

	// size register clamped to the fitted array
	function automatic logic [LOG2_W-1:0] eff_log2(input logic [SIZE_W-1:0] sz);
		logic [LOG2_W-1:0] r;
		if (sz > SIZE_W'(ADDR_BITS))
			r = LOG2_W'(ADDR_BITS);
		else
			r = LOG2_W'(sz);
		return r;
	endfunction

	function automatic logic [ADDR_BITS-1:0] size_mask(input logic [LOG2_W-1:0] e);
		logic [ADDR_BITS-1:0] m;
		for (int i = 0; i < ADDR_BITS; i++)
			m[i] = (LOG2_W'(i) < e);
		return m;
	endfunction

endpackage

### sv/ise_ram.sv
`timescale 1ns / 1ps
// Generic simple dual-port synchronous RAM, registered read data.
// No dependencies.
module ise_ram #(
	parameter int ADDR_W = 13,
	parameter int DATA_W = 8
) (
	input  logic              clk,
	input  logic              we,
	input  logic [ADDR_W-1:0] waddr,
	input  logic [DATA_W-1:0] wdata,
	input  logic              re,
	input  logic [ADDR_W-1:0] raddr,
	output logic [DATA_W-1:0] rdata
);

	logic [DATA_W-1:0] mem [(1 << ADDR_W)];

	always_ff @(posedge clk) begin
		if (we)
			mem[waddr] <= wdata;
	end

	always_ff @(posedge clk) begin
		if (re)
			rdata <= mem[raddr];
	end

endmodule

### sv/ise_ctrl.sv
`timescale 1ns / 1ps
// Bus protocol engine: pin tracking, phase sequencing, address and shift registers.
// Depends on ise_pkg; drives the cell array through an ise_ram_req_t.
module ise_ctrl (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        ev_valid,
	input  logic                        ev_cmd,
	input  logic                        ev_level,
	input  logic                        cfg_wr_en,
	input  logic [ise_pkg::SIZE_W-1:0]  cfg_wr_data,
	input  logic [7:0]                  rd_data,
	output ise_pkg::ise_ram_req_t       ram_req,
	output logic                        sda_line
);

	logic                           scl_q, sda_host_q, drive_q, pend_q;
	ise_pkg::ise_phase_t            phase_q;
	logic [3:0]                     bit_cnt_q;
	logic [7:0]                     shift_q;
	logic [ise_pkg::WADDR_W-1:0]    waddr_q;
	logic [ise_pkg::SIZE_W-1:0]     size_q;

	logic                           scl_n, sda_host_n, drive_n, pend_n;
	ise_pkg::ise_phase_t            phase_n;
	logic [3:0]                     bit_cnt_n, bc_dec;
	logic [7:0]                     sh, sh_n, sh_in;
	logic [ise_pkg::WADDR_W-1:0]    waddr_n, waddr_inc;
	logic [ise_pkg::LOG2_W-1:0]     eff;
	logic [ise_pkg::ADDR_BITS-1:0]  mask;
	logic [ise_pkg::WADDR_W-1:0]    mask_w;

	// read data lands in the cycle after the request: forward it
	assign sh        = pend_q ? rd_data : shift_q;
	assign eff       = ise_pkg::eff_log2(size_q);
	assign mask      = ise_pkg::size_mask(eff);
	assign mask_w    = ise_pkg::WADDR_W'(mask);
	assign bc_dec    = bit_cnt_q - 4'd1;
	assign sh_in     = {sh[6:0], sda_host_q};
	assign waddr_inc = (waddr_q + ise_pkg::WADDR_W'(1)) & mask_w;

	always_comb begin
		scl_n      = scl_q;
		sda_host_n = sda_host_q;
		drive_n    = drive_q;
		pend_n     = 1'b0;
		phase_n    = phase_q;
		bit_cnt_n  = bit_cnt_q;
		sh_n       = sh;
		waddr_n    = waddr_q;
		ram_req    = '0;
		if (ev_valid) begin
			if (ev_cmd) begin
				if (scl_q && ev_level && !sda_host_q) begin
					phase_n = ise_pkg::PH_IDLE;
					drive_n = 1'b1;
				end else if (scl_q && !ev_level && sda_host_q) begin
					phase_n   = ise_pkg::PH_START;
					drive_n   = 1'b1;
					bit_cnt_n = ise_pkg::BITS_PER_BYTE;
				end
				sda_host_n = ev_level;
			end else begin
				scl_n = ev_level;
				if (ev_level && !scl_q) begin
					unique case (phase_q)
						ise_pkg::PH_START, ise_pkg::PH_ADDR_HI,
						ise_pkg::PH_ADDR_LO, ise_pkg::PH_WRITE: begin
							sh_n      = sh_in;
							bit_cnt_n = bc_dec;
							if (bc_dec == 4'd0) begin
								unique case (phase_q)
									ise_pkg::PH_START: phase_n = ise_pkg::PH_DEV_ACK;
									ise_pkg::PH_ADDR_HI: begin
										waddr_n = {sh_in, 8'h00};
										phase_n = ise_pkg::PH_ADDR_HI_ACK;
									end
									ise_pkg::PH_ADDR_LO: begin
										waddr_n = waddr_q | ise_pkg::WADDR_W'(sh_in);
										phase_n = ise_pkg::PH_ADDR_LO_ACK;
									end
									default: begin
										ram_req.we    = 1'b1;
										ram_req.waddr = waddr_q[ise_pkg::ADDR_BITS-1:0] & mask;
										ram_req.wdata = sh_in;
										phase_n       = ise_pkg::PH_WRITE_ACK;
									end
								endcase
							end
						end
						ise_pkg::PH_DEV_ACK: begin
							bit_cnt_n = ise_pkg::BITS_PER_BYTE;
							if (sh[0]) begin
								phase_n       = ise_pkg::PH_READ;
								ram_req.re    = 1'b1;
								ram_req.raddr = waddr_q[ise_pkg::ADDR_BITS-1:0] & mask;
								pend_n        = 1'b1;
							end else if (eff < ise_pkg::LOG2_W'(ise_pkg::SMALL_LOG2)) begin
								waddr_n = ise_pkg::WADDR_W'(sh[7:1]);
								phase_n = ise_pkg::PH_WRITE;
							end else if (eff < ise_pkg::LOG2_W'(ise_pkg::MID_LOG2)) begin
								waddr_n = ise_pkg::WADDR_W'({sh[3:1], 8'h00});
								phase_n = ise_pkg::PH_ADDR_LO;
							end else begin
								phase_n = ise_pkg::PH_ADDR_HI;
							end
						end
						ise_pkg::PH_ADDR_HI_ACK: begin
							phase_n   = ise_pkg::PH_ADDR_LO;
							bit_cnt_n = ise_pkg::BITS_PER_BYTE;
						end
						ise_pkg::PH_ADDR_LO_ACK: begin
							phase_n   = ise_pkg::PH_WRITE;
							waddr_n   = waddr_q & mask_w;
							bit_cnt_n = ise_pkg::BITS_PER_BYTE;
						end
						ise_pkg::PH_READ: begin
							bit_cnt_n = bc_dec;
							if (bc_dec == 4'd0)
								phase_n = ise_pkg::PH_READ_ACK;
						end
						ise_pkg::PH_READ_ACK: begin
							phase_n       = ise_pkg::PH_READ;
							bit_cnt_n     = ise_pkg::BITS_PER_BYTE;
							waddr_n       = waddr_inc;
							ram_req.re    = 1'b1;
							ram_req.raddr = waddr_inc[ise_pkg::ADDR_BITS-1:0];
							pend_n        = 1'b1;
						end
						ise_pkg::PH_WRITE_ACK: begin
							phase_n   = ise_pkg::PH_WRITE;
							bit_cnt_n = ise_pkg::BITS_PER_BYTE;
							waddr_n   = waddr_inc;
						end
						default: ;
					endcase
				end else if (!ev_level && scl_q) begin
					unique case (phase_q)
						ise_pkg::PH_DEV_ACK, ise_pkg::PH_ADDR_HI_ACK,
						ise_pkg::PH_ADDR_LO_ACK, ise_pkg::PH_WRITE_ACK: drive_n = 1'b0;
						ise_pkg::PH_READ: begin
							drive_n = sh[7];
							sh_n    = {sh[6:0], 1'b0};
						end
						default: drive_n = 1'b1;
					endcase
				end
			end
		end
	end

	assign sda_line = sda_host_n & drive_n;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scl_q      <= 1'b0;
			sda_host_q <= 1'b0;
			drive_q    <= 1'b1;
			pend_q     <= 1'b0;
			phase_q    <= ise_pkg::PH_IDLE;
			bit_cnt_q  <= 4'd0;
			shift_q    <= 8'h00;
			waddr_q    <= '0;
			size_q     <= ise_pkg::SIZE_RESET;
		end else begin
			scl_q      <= scl_n;
			sda_host_q <= sda_host_n;
			drive_q    <= drive_n;
			pend_q     <= pend_n;
			phase_q    <= phase_n;
			bit_cnt_q  <= bit_cnt_n;
			shift_q    <= sh_n;
			waddr_q    <= waddr_n;
			if (cfg_wr_en)
				size_q <= cfg_wr_data;
		end
	end

endmodule

### sv/i2c_serial_eeprom_slave.sv
`timescale 1ns / 1ps
// Output: the sda_line result of an accepted pin event is registered into the result queue.
// Throughput: one pin event per cycle while s_axis_tready is high; the cell array read
// issued on a clock rise is forwarded to the shift register next cycle; nothing waits on it.
// Reset: control clears at once; the cell array is then swept to 0xFF, one byte a
// cycle, over 8192 cells, with s_axis_tready low. Configuration writes are taken throughout.
`include "assert_macros.svh"

// Top level of the serial EEPROM slave: event input, protocol engine, cell array,
// two-entry result queue. Depends on ise_pkg, ise_ctrl, ise_ram, assert_macros.svh.
module i2c_serial_eeprom_slave (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        s_axis_tvalid,
	output logic                        s_axis_tready,
	input  logic [7:0]                  s_axis_tdata,  // [0] level, [7:1] zero
	input  logic                        s_axis_tuser,  // [0] cmd (0 SCL, 1 SDA)
	output logic                        m_axis_tvalid,
	input  logic                        m_axis_tready,
	output logic [7:0]                  m_axis_tdata,  // [0] sda_line, [7:1] zero
	input  logic                        cfg_wr_en,
	input  logic [ise_pkg::SIZE_W-1:0]  cfg_wr_data
);

	// sweep counter: top bit set once every cell holds the erased value
	logic [ise_pkg::ADDR_BITS:0]   clr_q;
	logic                          clearing;

	logic                          in_acc, out_acc;
	logic                          res;
	ise_pkg::ise_ram_req_t         req;
	logic                          ram_we;
	logic [ise_pkg::ADDR_BITS-1:0] ram_waddr;
	logic [7:0]                    ram_wdata;
	logic [7:0]                    rd_data;

	// result queue: slot0 is the head
	logic [1:0]                    cnt_q;
	logic                          slot0_q, slot1_q;

	assign clearing      = !clr_q[ise_pkg::ADDR_BITS];
	assign s_axis_tready = !clearing && (cnt_q != 2'd2);
	assign in_acc        = s_axis_tvalid && s_axis_tready;
	assign out_acc       = m_axis_tvalid && m_axis_tready;
	assign m_axis_tvalid = (cnt_q != 2'd0);
	assign m_axis_tdata  = {7'd0, slot0_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q <= '0;
		end else if (clearing) begin
			clr_q <= clr_q + (ise_pkg::ADDR_BITS + 1)'(1);
		end
	end

	ise_ctrl u_ctrl (
		.clk         (clk),
		.arst_n      (arst_n),
		.ev_valid    (in_acc),
		.ev_cmd      (s_axis_tuser),
		.ev_level    (s_axis_tdata[0]),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data),
		.rd_data     (rd_data),
		.ram_req     (req),
		.sda_line    (res)
	);

	// the erase sweep owns the write port until it finishes
	assign ram_we    = clearing ? 1'b1 : req.we;
	assign ram_waddr = clearing ? clr_q[ise_pkg::ADDR_BITS-1:0] : req.waddr;
	assign ram_wdata = clearing ? ise_pkg::ERASED : req.wdata;

	ise_ram #(
		.ADDR_W (ise_pkg::ADDR_BITS),
		.DATA_W (8)
	) u_cells (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (req.re),
		.raddr (req.raddr),
		.rdata (rd_data)
	);

	// two slots let a new request in while a result waits downstream
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= 2'd0;
		end else begin
			priority if (in_acc && !out_acc)
				cnt_q <= cnt_q + 2'd1;
			else if (out_acc && !in_acc)
				cnt_q <= cnt_q - 2'd1;
		end
	end

	always_ff @(posedge clk) begin
		priority if (in_acc && out_acc) begin
			if (cnt_q == 2'd1) begin
				slot0_q <= res;
			end else begin
				slot0_q <= slot1_q;
				slot1_q <= res;
			end
		end else if (out_acc) begin
			slot0_q <= slot1_q;
		end else if (in_acc) begin
			if (cnt_q == 2'd0)
				slot0_q <= res;
			else
				slot1_q <= res;
		end
	end

	`ASSERT_IMP(a_no_req_in_sweep, clk, arst_n, clearing, !s_axis_tready, "request taken during erase sweep")
	`ASSERT_ALWAYS(a_cnt_bound, clk, arst_n, cnt_q != 2'd3, "result queue overflow")
	`ASSERT_ALWAYS(a_ram_port, clk, arst_n, !(req.we && req.re), "cell read and write in one cycle")
	`ASSERT_NXT(a_res_follows, clk, arst_n, in_acc, m_axis_tvalid, "no result after request")

endmodule
